// File: rtl/core/ftr_pkg.sv
// Shared codes, widths and types for the framed transfer receiver.
`timescale 1ns / 1ps

package ftr_pkg;

   localparam int LENGTH_BYTES_DEFAULT = 4;

   localparam int OP_W    = 2;
   localparam int STATE_W = 3;
   localparam int KIND_W  = 2;
   localparam int PHASE_W = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
   localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

   localparam logic [STATE_W-1:0] ST_IDLE         = 3'd0;
   localparam logic [STATE_W-1:0] ST_WAITING      = 3'd1;
   localparam logic [STATE_W-1:0] ST_TRANSFERRING = 3'd2;
   localparam logic [STATE_W-1:0] ST_PAUSED       = 3'd3;
   localparam logic [STATE_W-1:0] ST_CANCELLED    = 3'd4;
   localparam logic [STATE_W-1:0] ST_DISCONNECTED = 3'd5;
   localparam logic [STATE_W-1:0] ST_FINISHED     = 3'd6;

   localparam logic [KIND_W-1:0] KIND_STATE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_LEN = 2'd3;

   localparam logic [PHASE_W-1:0] PH_LENGTH  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_TYPE    = 2'd1;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd2;

   typedef struct packed {
      logic [STATE_W-1:0] cur_state;
      logic               state_changed;
      logic               may_pause;
      logic               may_resume;
      logic               may_cancel;
   } xfer_view_type;

endpackage

// File: rtl/core/ftr_xfer_fsm.sv
// Transfer state machine with prior-state tracking and capability flags.
`timescale 1ns / 1ps

module ftr_xfer_fsm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_en,
   input  logic [ftr_pkg::STATE_W-1:0] req_state,
   output logic [ftr_pkg::STATE_W-1:0] state,
   output ftr_pkg::xfer_view_type      view
);

   logic [ftr_pkg::STATE_W-1:0] state_ff, state_in;
   logic [ftr_pkg::STATE_W-1:0] prior_ff, prior_in;
   logic [ftr_pkg::STATE_W-1:0] granted;

   always_comb begin
      granted = state_ff;
      unique case (state_ff)
         ftr_pkg::ST_IDLE: begin
            if (req_state == ftr_pkg::ST_WAITING) granted = req_state;
         end
         ftr_pkg::ST_WAITING: begin
            if (req_state == ftr_pkg::ST_TRANSFERRING || req_state == ftr_pkg::ST_CANCELLED ||
                req_state == ftr_pkg::ST_PAUSED) granted = req_state;
         end
         ftr_pkg::ST_TRANSFERRING: begin
            if (req_state == ftr_pkg::ST_DISCONNECTED || req_state == ftr_pkg::ST_FINISHED ||
                req_state == ftr_pkg::ST_CANCELLED || req_state == ftr_pkg::ST_PAUSED)
               granted = req_state;
         end
         ftr_pkg::ST_PAUSED: begin
            if (req_state == ftr_pkg::ST_WAITING || req_state == ftr_pkg::ST_TRANSFERRING)
               granted = prior_ff;
            else if (req_state == ftr_pkg::ST_CANCELLED ||
                     req_state == ftr_pkg::ST_DISCONNECTED)
               granted = req_state;
         end
         default: granted = state_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      prior_in = prior_ff;
      if (req_en && req_state != state_ff) begin
         state_in = granted;
         prior_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ftr_pkg::ST_IDLE;
         prior_ff <= ftr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
         prior_ff <= prior_in;
      end
   end

   assign state = state_ff;

   always_comb begin
      view.cur_state     = state_in;
      view.state_changed = (state_in != state_ff);
      view.may_pause     = (state_in == ftr_pkg::ST_WAITING) ||
                           (state_in == ftr_pkg::ST_TRANSFERRING);
      view.may_resume    = (state_in == ftr_pkg::ST_PAUSED);
      view.may_cancel    = (state_in == ftr_pkg::ST_WAITING) ||
                           (state_in == ftr_pkg::ST_TRANSFERRING) ||
                           (state_in == ftr_pkg::ST_PAUSED);
   end

endmodule

// File: rtl/core/framed_transfer_receiver_core.sv
// Top level: input register, length-prefixed packet parser and result register.
`timescale 1ns / 1ps

// Framed transfer receiver.
// The req_ channel carries one transfer per cycle: a stream byte, a state
// change request or a parser clear, selected by req_tuser. Stream bytes form
// packets of a little-endian length, a type byte and that many payload bytes;
// each payload byte leaves on the rsp_ channel with rsp_tlast on the final
// one. A zero length gives one empty-packet transfer, a length with its top
// bit set gives one bad-length transfer. Every state request gives one state
// report. Length and type bytes, clears and dropped bytes give no transfer.
// A transfer lands in the input register at the accepting edge; the result
// register loads from it once the result register is empty or rsp_tready
// is high. Throughput is one transfer per cycle while rsp_tready is high,
// set by the combinational parser update between the two registers.
// When rsp_tready is low the result register holds, the input register fills
// and then req_tready drops until the result is taken.
// Reset returns the transfer state to idle and the parser to length
// collection, and empties both registers.
module framed_transfer_receiver_core #(
   parameter int LENGTH_BYTES = ftr_pkg::LENGTH_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [7:0] rx_byte, [10:8] requested_state, [15:11] zero
   input  logic [ftr_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [ftr_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [2:0] cur_state, [3] state_changed, [4] may_pause, [5] may_resume,
   // [6] may_cancel, [14:7] frame_type, [22:15] payload_byte, [23] zero
   output logic [ftr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] kind
   output logic [ftr_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                           rsp_tlast
);

   localparam int LEN_W = 8 * LENGTH_BYTES;
   localparam int REM_W = LEN_W - 1;
   localparam int CNT_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LENGTH_BYTES - 1);

   logic                          in_valid_ff, in_valid_in;
   logic [ftr_pkg::OP_W-1:0]      in_op_ff;
   logic [7:0]                    in_byte_ff;
   logic [ftr_pkg::STATE_W-1:0]   in_req_ff;

   logic [ftr_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [LEN_W-1:0]              shift_ff, shift_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [7:0]                    type_ff, type_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ftr_pkg::KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [ftr_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          advance;
   logic                          req_strobe;
   logic [ftr_pkg::STATE_W-1:0]   xfer_state;
   ftr_pkg::xfer_view_type        view;

   logic                          emit;
   logic [ftr_pkg::KIND_W-1:0]    emit_kind;
   logic [7:0]                    emit_type;
   logic [7:0]                    emit_byte;
   logic                          emit_last;
   logic [LEN_W-1:0]              len_full;
   logic [REM_W-1:0]              rem_dec;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_strobe = advance && (in_op_ff == ftr_pkg::OP_REQUEST);

   ftr_xfer_fsm u_xfer_fsm (
      .clock     (clock),
      .reset     (reset),
      .req_en    (req_strobe),
      .req_state (in_req_ff),
      .state     (xfer_state),
      .view      (view)
   );

   assign len_full = shift_ff | (LEN_W'(in_byte_ff) << {cnt_ff, 3'b000});
   assign rem_dec  = rem_ff - REM_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      rem_in    = rem_ff;
      type_in   = type_ff;
      emit      = 1'b0;
      emit_kind = ftr_pkg::KIND_STATE;
      emit_type = 8'd0;
      emit_byte = 8'd0;
      emit_last = 1'b0;
      if (advance) begin
         priority if (in_op_ff == ftr_pkg::OP_REQUEST) begin
            emit = 1'b1;
         end else if (in_op_ff == ftr_pkg::OP_CLEAR) begin
            phase_in = ftr_pkg::PH_LENGTH;
            cnt_in   = '0;
            shift_in = '0;
            rem_in   = '0;
            type_in  = 8'd0;
         end else if (in_op_ff == ftr_pkg::OP_BYTE && xfer_state != ftr_pkg::ST_CANCELLED) begin
            unique case (phase_ff)
               ftr_pkg::PH_TYPE: begin
                  if (rem_ff == '0) begin
                     emit      = 1'b1;
                     emit_kind = ftr_pkg::KIND_EMPTY;
                     emit_type = in_byte_ff;
                     emit_last = 1'b1;
                     phase_in  = ftr_pkg::PH_LENGTH;
                     type_in   = 8'd0;
                  end else begin
                     type_in  = in_byte_ff;
                     phase_in = ftr_pkg::PH_PAYLOAD;
                  end
               end
               ftr_pkg::PH_PAYLOAD: begin
                  emit      = 1'b1;
                  emit_kind = ftr_pkg::KIND_PAYLOAD;
                  emit_type = type_ff;
                  emit_byte = in_byte_ff;
                  emit_last = (rem_dec == '0);
                  if (rem_dec == '0) begin
                     phase_in = ftr_pkg::PH_LENGTH;
                     cnt_in   = '0;
                     shift_in = '0;
                     rem_in   = '0;
                     type_in  = 8'd0;
                  end else begin
                     rem_in = rem_dec;
                  end
               end
               default: begin
                  phase_in = ftr_pkg::PH_LENGTH;
                  if (cnt_ff == CNT_LAST) begin
                     cnt_in   = '0;
                     shift_in = '0;
                     if (len_full[LEN_W-1]) begin
                        emit      = 1'b1;
                        emit_kind = ftr_pkg::KIND_BAD_LEN;
                        rem_in    = '0;
                        type_in   = 8'd0;
                     end else begin
                        rem_in   = len_full[REM_W-1:0];
                        phase_in = ftr_pkg::PH_TYPE;
                     end
                  end else begin
                     cnt_in   = cnt_ff + CNT_W'(1);
                     shift_in = len_full;
                  end
               end
            endcase
         end else begin
            emit = 1'b0;
         end
      end
   end

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      rsp_valid_in = advance ? emit : (rsp_valid_ff && !rsp_tready);
      rsp_kind_in  = emit_kind;
      rsp_last_in  = emit_last;
      rsp_data_in  = {1'b0, emit_byte, emit_type, view.may_cancel, view.may_resume,
                      view.may_pause, (in_op_ff == ftr_pkg::OP_REQUEST) && view.state_changed,
                      view.cur_state};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= ftr_pkg::PH_LENGTH;
         cnt_ff       <= '0;
         shift_ff     <= '0;
         rem_ff       <= '0;
         type_ff      <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         shift_ff     <= shift_in;
         rem_ff       <= rem_in;
         type_ff      <= type_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata[7:0];
         in_req_ff  <= req_tdata[10:8];
      end
      if (advance && emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != ftr_pkg::KIND_STATE |-> !rsp_data_ff[3])
      else $error("state_changed set on a non-report result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |->
         (rsp_kind_ff == ftr_pkg::KIND_PAYLOAD || rsp_kind_ff == ftr_pkg::KIND_EMPTY))
      else $error("last mark on a result that ends no packet");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == ftr_pkg::PH_PAYLOAD |-> rem_ff != '0)
      else $error("payload phase with no bytes remaining");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff != ftr_pkg::PH_LENGTH |-> cnt_ff == '0 && shift_ff == '0)
      else $error("length collector not cleared outside length phase");

   assert property (@(posedge clock) disable iff (reset)
      advance && in_op_ff == ftr_pkg::OP_BYTE && xfer_state == ftr_pkg::ST_CANCELLED |=>
         !$changed(phase_ff) && !$changed(rem_ff))
      else $error("parser moved on a byte dropped while cancelled");
`endif

endmodule
